@@ hw/rtl/limit_order_book_matcher_defines.svh @@
// assertion macros for the limit order book matcher checker
// used by limit_order_book_matcher_chk.sv, no other dependencies
`ifndef LIMIT_ORDER_BOOK_MATCHER_DEFINES_SVH
`define LIMIT_ORDER_BOOK_MATCHER_DEFINES_SVH

// implication checked on every rising clock edge out of reset
`define LOBM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lobm assertion failed");

// consequence checked in the cycle after the antecedent
`define LOBM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lobm assertion failed");

`endif

@@ hw/rtl/lobm_pkg.sv @@
// shared types and constants for the limit order book matcher
// no dependencies
`timescale 1ns / 1ps

package lobm_pkg;

    localparam int SIDE_DEPTH = 32;

    localparam logic [2:0] STATUS_RESTED  = 3'd0;
    localparam logic [2:0] STATUS_PARTIAL = 3'd1;
    localparam logic [2:0] STATUS_FILLED  = 3'd2;
    localparam logic [2:0] STATUS_MKT_DROP = 3'd3;
    localparam logic [2:0] STATUS_FULL_DROP = 3'd4;

    typedef struct packed {
        logic        valid;
        logic [31:0] price;
        logic [31:0] qty;
        logic [31:0] ident;
    } entry_t;

    typedef struct packed {
        logic        drop;
        logic        sub;
        logic        ins;
        logic [31:0] sub_qty;
        logic [31:0] new_price;
        logic [31:0] new_qty;
        logic [31:0] new_ident;
    } chain_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_DONE
    } state_t;

endpackage

@@ hw/rtl/lobm_cell.sv @@
// one slot of a sorted book side, trades data with its neighbors
// depends on lobm_pkg
`timescale 1ns / 1ps

module lobm_cell
    import lobm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      desc,
    input  logic      head,
    input  chain_op_t op,
    input  entry_t    left_entry,
    input  logic      left_keep,
    input  entry_t    right_entry,
    output entry_t    entry,
    output logic      keep
);

    entry_t entry_reg;
    entry_t entry_next;

    // entry stays ahead of a new order at the same or better price
    assign keep = entry_reg.valid &&
                  (desc ? (entry_reg.price >= op.new_price) : (entry_reg.price <= op.new_price));
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (op.drop)
        begin
            entry_next = right_entry;
        end
        else if (op.ins)
        begin
            if (keep)
            begin
                entry_next = entry_reg;
            end
            else if (left_keep)
            begin
                entry_next.valid = 1'b1;
                entry_next.price = op.new_price;
                entry_next.qty   = op.new_qty;
                entry_next.ident = op.new_ident;
            end
            else
            begin
                entry_next = left_entry;
            end
        end
        else if (op.sub && head)
        begin
            entry_next.qty = entry_reg.qty - op.sub_qty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

@@ hw/rtl/lobm_chain.sv @@
// one side of the book: a row of sorted cells, best price at slot 0
// depends on lobm_pkg and lobm_cell
`timescale 1ns / 1ps

module lobm_chain
    import lobm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      desc,
    input  chain_op_t op,
    output entry_t    head,
    output logic      full
);

    entry_t entries [SIDE_DEPTH];
    logic   keeps   [SIDE_DEPTH];

    genvar i;
    generate
        for (i = 0; i < SIDE_DEPTH; i++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_k;
            if (i == 0)
            begin : g_first
                assign left_e = '0;
                assign left_k = 1'b1;
            end
            else
            begin : g_mid
                assign left_e = entries[i-1];
                assign left_k = keeps[i-1];
            end
            if (i == SIDE_DEPTH - 1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_inner
                assign right_e = entries[i+1];
            end
            lobm_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .desc        (desc),
                .head        ((i == 0) ? 1'b1 : 1'b0),
                .op          (op),
                .left_entry  (left_e),
                .left_keep   (left_k),
                .right_entry (right_e),
                .entry       (entries[i]),
                .keep        (keeps[i])
            );
        end
    endgenerate

    assign head = entries[0];
    assign full = entries[SIDE_DEPTH-1].valid;

endmodule

@@ hw/rtl/limit_order_book_matcher.sv @@
// limit order book matcher: one order in, its fills and final status out
// flow: an accepted order matches against the opposite book, each fill one step of the book chains,
// then the done state sends the last result; a new order is taken only after that, back in idle
// result stalls hold both the fills and the done state
// reset: books empty, fill counter zero, no result pending
// depends on lobm_pkg and lobm_chain
`timescale 1ns / 1ps

module limit_order_book_matcher
    import lobm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        side,
    input  logic        order_kind,
    input  logic [31:0] limit_price,
    input  logic [31:0] order_quantity,
    input  logic [31:0] order_ident,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        fill_valid,
    output logic [31:0] fill_number,
    output logic [31:0] buyer_ident,
    output logic [31:0] seller_ident,
    output logic [31:0] trade_quantity,
    output logic [31:0] fill_price,
    output logic [2:0]  final_status,
    output logic        last_result
);

    state_t state_reg, state_next;

    logic        sell_reg, market_reg;
    logic [31:0] price_reg, qty_reg, ident_reg, remain_reg, counter_reg;
    logic        has_pend_reg;
    logic [31:0] pend_buyer_reg, pend_seller_reg, pend_qty_reg, pend_price_reg, pend_num_reg;
    logic [2:0]  status_reg;
    logic        out_valid_reg, out_fill_reg, out_last_reg;
    logic [31:0] out_num_reg, out_buyer_reg, out_seller_reg, out_qty_reg, out_price_reg;
    logic [2:0]  out_status_reg;

    entry_t    bid_head, ask_head, opp_head;
    logic      bid_full, ask_full, own_full;
    chain_op_t bid_op, ask_op, opp_op, own_op;

    logic        price_ok, trade_ok, out_free;
    logic        do_trade, do_insert, push_pend, finish, accept;
    logic [31:0] tq;
    logic [2:0]  status_now;

    assign opp_head = sell_reg ? bid_head : ask_head;
    assign own_full = sell_reg ? ask_full : bid_full;
    assign price_ok = sell_reg ? (opp_head.price >= price_reg) : (opp_head.price <= price_reg);
    assign trade_ok = (remain_reg != '0) && opp_head.valid && (market_reg || price_ok);
    assign out_free = !out_valid_reg || !out_stall;
    assign tq       = (remain_reg < opp_head.qty) ? remain_reg : opp_head.qty;
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    always_comb
    begin
        if (remain_reg == '0)
            status_now = STATUS_FILLED;
        else if (market_reg)
            status_now = STATUS_MKT_DROP;
        else if (own_full)
            status_now = STATUS_FULL_DROP;
        else if (remain_reg < qty_reg)
            status_now = STATUS_PARTIAL;
        else
            status_now = STATUS_RESTED;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_MATCH;
            S_MATCH: if (!trade_ok) state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        do_trade  = 1'b0;
        do_insert = 1'b0;
        finish    = 1'b0;
        case (state_reg)
            S_MATCH:
            begin
                do_trade  = trade_ok && (!has_pend_reg || out_free);
                do_insert = !trade_ok && (remain_reg != '0) && !market_reg && !own_full;
            end
            S_DONE:  finish = out_free;
            default: ;
        endcase
        push_pend = do_trade && has_pend_reg;
    end

    always_comb
    begin
        opp_op           = '0;
        opp_op.drop      = do_trade && (tq == opp_head.qty);
        opp_op.sub       = do_trade && (tq != opp_head.qty);
        opp_op.sub_qty   = tq;
        own_op           = '0;
        own_op.ins       = do_insert;
        own_op.new_price = price_reg;
        own_op.new_qty   = remain_reg;
        own_op.new_ident = ident_reg;
        bid_op = sell_reg ? opp_op : own_op;
        ask_op = sell_reg ? own_op : opp_op;
    end

    lobm_chain u_bids (
        .clk   (clk),
        .rst_n (rst_n),
        .desc  (1'b1),
        .op    (bid_op),
        .head  (bid_head),
        .full  (bid_full)
    );

    lobm_chain u_asks (
        .clk   (clk),
        .rst_n (rst_n),
        .desc  (1'b0),
        .op    (ask_op),
        .head  (ask_head),
        .full  (ask_full)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            counter_reg   <= '0;
            has_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                has_pend_reg <= 1'b0;
            end
            else if (do_trade)
            begin
                has_pend_reg <= 1'b1;
                counter_reg  <= counter_reg + 32'd1;
            end
            if (push_pend || finish)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sell_reg   <= side;
            market_reg <= order_kind;
            price_reg  <= limit_price;
            qty_reg    <= order_quantity;
            ident_reg  <= order_ident;
            remain_reg <= order_quantity;
        end
        else if (do_trade)
        begin
            remain_reg <= remain_reg - tq;
        end
        if (do_trade)
        begin
            pend_num_reg    <= counter_reg;
            pend_buyer_reg  <= sell_reg ? opp_head.ident : ident_reg;
            pend_seller_reg <= sell_reg ? ident_reg : opp_head.ident;
            pend_qty_reg    <= tq;
            pend_price_reg  <= opp_head.price;
        end
        if ((state_reg == S_MATCH) && !trade_ok)
            status_reg <= status_now;
        if (push_pend || finish)
        begin
            out_fill_reg   <= has_pend_reg;
            out_num_reg    <= has_pend_reg ? pend_num_reg : '0;
            out_buyer_reg  <= has_pend_reg ? pend_buyer_reg : '0;
            out_seller_reg <= has_pend_reg ? pend_seller_reg : '0;
            out_qty_reg    <= has_pend_reg ? pend_qty_reg : '0;
            out_price_reg  <= has_pend_reg ? pend_price_reg : '0;
            out_status_reg <= finish ? status_reg : STATUS_RESTED;
            out_last_reg   <= finish;
        end
    end

    assign out_valid      = out_valid_reg;
    assign fill_valid     = out_fill_reg;
    assign fill_number    = out_num_reg;
    assign buyer_ident    = out_buyer_reg;
    assign seller_ident   = out_seller_reg;
    assign trade_quantity = out_qty_reg;
    assign fill_price     = out_price_reg;
    assign final_status   = out_status_reg;
    assign last_result    = out_last_reg;

endmodule

@@ hw/rtl/limit_order_book_matcher_chk.sv @@
// port-level checker for the limit order book matcher, bound to the top level
// depends on lobm_pkg and limit_order_book_matcher_defines.svh
`timescale 1ns / 1ps
`include "limit_order_book_matcher_defines.svh"

module limit_order_book_matcher_chk
    import lobm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        fill_valid,
    input logic [31:0] fill_number,
    input logic [31:0] trade_quantity,
    input logic [2:0]  final_status,
    input logic        last_result
);

    `LOBM_ASSERT_NEXT(a_busy_after_request, in_valid && !in_stall, in_stall)
    `LOBM_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid)
    `LOBM_ASSERT_IMP(a_mid_is_fill, out_valid && !last_result, fill_valid && (final_status == STATUS_RESTED))
    `LOBM_ASSERT_IMP(a_status_only_zero, out_valid && !fill_valid, (fill_number == 32'd0) && (trade_quantity == 32'd0) && last_result)

endmodule

bind limit_order_book_matcher limit_order_book_matcher_chk u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .fill_valid     (fill_valid),
    .fill_number    (fill_number),
    .trade_quantity (trade_quantity),
    .final_status   (final_status),
    .last_result    (last_result)
);
